### design/spd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sheared periodic pair distance pipeline.
// No dependencies.
package spd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int LEN_W   = 31;
    localparam int RECIP_W = 32;
    localparam int GAMMA_W = 32;
    localparam int OUT_W   = 32;

    // image offset magnitude kept after the cap check, shear shift after its cap check
    localparam int OFF_W  = 53;
    localparam int SM_W   = 51;
    localparam int COMP_W = 32;
    localparam int SQ_W   = 64;

    localparam logic [63:0] OFFSET_CAP = 64'h0010_0000_0000_0000;
    localparam logic [63:0] SHIFT_CAP  = 64'h0004_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RECIP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR      = 2'd2;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 31'd65536;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [LEN_W-1:0]   box_length;
        logic [RECIP_W-1:0] recip;
        logic [GAMMA_W-1:0] gamma_mag;
        logic               gamma_neg;
    } cfg_t;

endpackage

### design/spd_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: box length, reciprocal and shear strain.
// Depends on spd_pkg.
module spd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output spd_pkg::cfg_t                 cfg
);
    import spd_pkg::*;

    logic [LEN_W-1:0]   len_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [GAMMA_W-1:0] gamma_mag_reg;
    logic [GAMMA_W-1:0] gamma_mag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LEN_RESET;
            recip_reg <= RECIP_RESET;
            gamma_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BOX_LENGTH: len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_BOX_RECIP:  recip_reg <= cfg_wdata[RECIP_W-1:0];
                REG_SHEAR:      gamma_reg <= cfg_wdata[GAMMA_W-1:0];
                default: ;
            endcase
        end
    end

    assign gamma_mag_next = gamma_reg[GAMMA_W-1] ? (~gamma_reg + 1'b1) : gamma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_mag_reg <= '0;
        end else begin
            gamma_mag_reg <= gamma_mag_next;
        end
    end

    assign cfg.box_length = len_reg;
    assign cfg.recip      = recip_reg;
    assign cfg.gamma_mag  = gamma_mag_reg;
    assign cfg.gamma_neg  = gamma_reg[GAMMA_W-1];

endmodule

### design/spd_image.sv
`timescale 1ns / 1ps
// Differences, y/z image offsets and shear shift of x: eight register stages.
// Depends on spd_pkg.
module spd_image #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [COORD_WIDTH-1:0]     first_x,
    input  logic [COORD_WIDTH-1:0]     first_y,
    input  logic [COORD_WIDTH-1:0]     first_z,
    input  logic [COORD_WIDTH-1:0]     second_x,
    input  logic [COORD_WIDTH-1:0]     second_y,
    input  logic [COORD_WIDTH-1:0]     second_z,
    input  spd_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output logic [COORD_WIDTH:0]       dx,
    output logic [COORD_WIDTH:0]       dy,
    output logic [COORD_WIDTH:0]       dz,
    output logic [spd_pkg::OFF_W-1:0]  off_y,
    output logic [spd_pkg::OFF_W-1:0]  off_z,
    output logic [spd_pkg::SM_W-1:0]   shift,
    output logic                       shift_neg,
    output logic                       over
);
    import spd_pkg::*;

    localparam int STAGES = 8;
    localparam int DW     = COORD_WIDTH + 1;
    localparam int SPA    = (DW + 1) / 2;
    localparam int MAXCF  = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS;
    localparam int SUMW   = MAXCF + 34;
    localparam int CNTW   = SUMW - RECIP_W - FRAC_BITS;
    localparam int PAL_W  = SPA + RECIP_W;
    localparam int PAH_W  = DW - SPA + RECIP_W;
    localparam int SPB    = (CNTW + 1) / 2;
    localparam int PBL_W  = SPB + LEN_W;
    localparam int PBH_W  = CNTW - SPB + LEN_W;
    localparam int MW     = ((CNTW + LEN_W) > OFF_W) ? (CNTW + LEN_W) : (OFF_W + 1);
    localparam int SPC    = (OFF_W + 1) / 2;
    localparam int PCL_W  = SPC + GAMMA_W;
    localparam int PCH_W  = OFF_W - SPC + GAMMA_W;
    localparam int SHW    = OFF_W + GAMMA_W + 1;

    localparam logic [SUMW-1:0] ROUND_A = SUMW'(1) << (RECIP_W + FRAC_BITS - 1);
    localparam logic [SHW-1:0]  ROUND_S = SHW'(1) << (FRAC_BITS - 1);

    logic [STAGES-1:0] vld_reg;
    logic [DW-1:0]     dx_reg [STAGES];
    logic [DW-1:0]     dy_reg [STAGES];
    logic [DW-1:0]     dz_reg [STAGES];

    logic [DW-1:0]    s2_mag_y_reg, s2_mag_z_reg;
    logic [PAL_W-1:0] s3_pal_y_reg, s3_pal_z_reg;
    logic [PAH_W-1:0] s3_pah_y_reg, s3_pah_z_reg;
    logic [CNTW-1:0]  s4_cnt_y_reg, s4_cnt_z_reg;
    logic [PBL_W-1:0] s5_pbl_y_reg, s5_pbl_z_reg;
    logic [PBH_W-1:0] s5_pbh_y_reg, s5_pbh_z_reg;
    logic [OFF_W-1:0] s6_off_y_reg, s6_off_z_reg;
    logic [OFF_W-1:0] s7_off_y_reg, s7_off_z_reg;
    logic [OFF_W-1:0] s8_off_y_reg, s8_off_z_reg;
    logic             s6_over_reg, s7_over_reg, s8_over_reg;
    logic [PCL_W-1:0] s7_pcl_reg;
    logic [PCH_W-1:0] s7_pch_reg;
    logic [SM_W-1:0]  s8_shift_reg;
    logic             s8_shift_neg_reg;

    logic [SUMW-1:0] sum_y, sum_z;
    logic [MW-1:0]   m_y, m_z;
    logic [SHW-1:0]  shear_full, shear_q;

    always_comb begin
        sum_y      = (SUMW'(s3_pah_y_reg) << SPA) + SUMW'(s3_pal_y_reg) + ROUND_A;
        sum_z      = (SUMW'(s3_pah_z_reg) << SPA) + SUMW'(s3_pal_z_reg) + ROUND_A;
        m_y        = (MW'(s5_pbh_y_reg) << SPB) + MW'(s5_pbl_y_reg);
        m_z        = (MW'(s5_pbh_z_reg) << SPB) + MW'(s5_pbl_z_reg);
        shear_full = (SHW'(s7_pch_reg) << SPC) + SHW'(s7_pcl_reg) + ROUND_S;
        shear_q    = shear_full >> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: raw differences
            dx_reg[0] <= {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
            dy_reg[0] <= {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};
            dz_reg[0] <= {first_z[COORD_WIDTH-1], first_z} - {second_z[COORD_WIDTH-1], second_z};
            for (int i = 1; i < STAGES; i++) begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
                dz_reg[i] <= dz_reg[i-1];
            end
            // stage 2: magnitudes
            s2_mag_y_reg <= dy_reg[0][DW-1] ? (~dy_reg[0] + 1'b1) : dy_reg[0];
            s2_mag_z_reg <= dz_reg[0][DW-1] ? (~dz_reg[0] + 1'b1) : dz_reg[0];
            // stage 3: |d| * recip, split in halves
            s3_pal_y_reg <= PAL_W'(s2_mag_y_reg[SPA-1:0]) * PAL_W'(cfg.recip);
            s3_pah_y_reg <= PAH_W'(s2_mag_y_reg[DW-1:SPA]) * PAH_W'(cfg.recip);
            s3_pal_z_reg <= PAL_W'(s2_mag_z_reg[SPA-1:0]) * PAL_W'(cfg.recip);
            s3_pah_z_reg <= PAH_W'(s2_mag_z_reg[DW-1:SPA]) * PAH_W'(cfg.recip);
            // stage 4: rounded image count
            s4_cnt_y_reg <= sum_y[SUMW-1 -: CNTW];
            s4_cnt_z_reg <= sum_z[SUMW-1 -: CNTW];
            // stage 5: count * L, split in halves
            s5_pbl_y_reg <= PBL_W'(s4_cnt_y_reg[SPB-1:0]) * PBL_W'(cfg.box_length);
            s5_pbh_y_reg <= PBH_W'(s4_cnt_y_reg[CNTW-1:SPB]) * PBH_W'(cfg.box_length);
            s5_pbl_z_reg <= PBL_W'(s4_cnt_z_reg[SPB-1:0]) * PBL_W'(cfg.box_length);
            s5_pbh_z_reg <= PBH_W'(s4_cnt_z_reg[CNTW-1:SPB]) * PBH_W'(cfg.box_length);
            // stage 6: offset magnitude and cap
            s6_off_y_reg <= m_y[OFF_W-1:0];
            s6_off_z_reg <= m_z[OFF_W-1:0];
            s6_over_reg  <= (m_y > MW'(OFFSET_CAP)) || (m_z > MW'(OFFSET_CAP));
            // stage 7: |offset_y| * |gamma|, split in halves
            s7_pcl_reg   <= PCL_W'(s6_off_y_reg[SPC-1:0]) * PCL_W'(cfg.gamma_mag);
            s7_pch_reg   <= PCH_W'(s6_off_y_reg[OFF_W-1:SPC]) * PCH_W'(cfg.gamma_mag);
            s7_off_y_reg <= s6_off_y_reg;
            s7_off_z_reg <= s6_off_z_reg;
            s7_over_reg  <= s6_over_reg;
            // stage 8: rounded shear shift and cap
            s8_shift_reg     <= shear_q[SM_W-1:0];
            s8_shift_neg_reg <= dy_reg[STAGES-2][DW-1] ^ cfg.gamma_neg;
            s8_over_reg      <= s7_over_reg || (shear_q > SHW'(SHIFT_CAP));
            s8_off_y_reg     <= s7_off_y_reg;
            s8_off_z_reg     <= s7_off_z_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign dx        = dx_reg[STAGES-1];
    assign dy        = dy_reg[STAGES-1];
    assign dz        = dz_reg[STAGES-1];
    assign off_y     = s8_off_y_reg;
    assign off_z     = s8_off_z_reg;
    assign shift     = s8_shift_reg;
    assign shift_neg = s8_shift_neg_reg;
    assign over      = s8_over_reg;

endmodule

### design/spd_resid.sv
`timescale 1ns / 1ps
// Wrapped components, range check and sum of squares: four register stages.
// Depends on spd_pkg.
module spd_resid #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [COORD_WIDTH:0]       dx,
    input  logic [COORD_WIDTH:0]       dy,
    input  logic [COORD_WIDTH:0]       dz,
    input  logic [spd_pkg::OFF_W-1:0]  off_y,
    input  logic [spd_pkg::OFF_W-1:0]  off_z,
    input  logic [spd_pkg::SM_W-1:0]   shift,
    input  logic                       shift_neg,
    input  logic                       in_over,
    output logic                       out_valid,
    output logic [spd_pkg::SQ_W-1:0]   sum_sq,
    output logic                       out_over
);
    import spd_pkg::*;

    localparam int STAGES = 4;
    localparam int DW     = COORD_WIDTH + 1;
    localparam int RW     = ((DW > OFF_W + 1) ? DW : (OFF_W + 1)) + 1;
    localparam int SUM_W  = SQ_W + 2;

    logic [STAGES-1:0] vld_reg;
    logic [RW-1:0]     rx_reg, ry_reg, rz_reg;
    logic              s9_over_reg;
    logic [COMP_W-1:0] ax_reg, ay_reg, az_reg;
    logic              s10_over_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic              s11_over_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic              s12_over_reg;

    logic [RW-1:0]    sx, sy, sz, ush, uoy, uoz;
    logic [RW-1:0]    mx, my, mz;
    logic             big;
    logic [SUM_W-1:0] total;

    always_comb begin
        sx    = {{(RW - DW){dx[DW-1]}}, dx};
        sy    = {{(RW - DW){dy[DW-1]}}, dy};
        sz    = {{(RW - DW){dz[DW-1]}}, dz};
        ush   = {{(RW - SM_W){1'b0}}, shift};
        uoy   = {{(RW - OFF_W){1'b0}}, off_y};
        uoz   = {{(RW - OFF_W){1'b0}}, off_z};
        mx    = rx_reg[RW-1] ? (~rx_reg + 1'b1) : rx_reg;
        my    = ry_reg[RW-1] ? (~ry_reg + 1'b1) : ry_reg;
        mz    = rz_reg[RW-1] ? (~rz_reg + 1'b1) : rz_reg;
        big   = (|mx[RW-1:COMP_W]) || (|my[RW-1:COMP_W]) || (|mz[RW-1:COMP_W]);
        total = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // negative image offset on an axis means the offset is added back
            rx_reg       <= shift_neg ? (sx + ush) : (sx - ush);
            ry_reg       <= dy[DW-1] ? (sy + uoy) : (sy - uoy);
            rz_reg       <= dz[DW-1] ? (sz + uoz) : (sz - uoz);
            s9_over_reg  <= in_over;
            ax_reg       <= mx[COMP_W-1:0];
            ay_reg       <= my[COMP_W-1:0];
            az_reg       <= mz[COMP_W-1:0];
            s10_over_reg <= s9_over_reg || big;
            sqx_reg      <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg      <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            sqz_reg      <= SQ_W'(az_reg) * SQ_W'(az_reg);
            s11_over_reg <= s10_over_reg;
            sum_reg      <= total[SQ_W-1:0];
            s12_over_reg <= s11_over_reg || (|total[SUM_W-1:SQ_W]);
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign sum_sq    = sum_reg;
    assign out_over  = s12_over_reg;

endmodule

### design/spd_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of a 64-bit sum, one root bit per stage; all ones when in_over is set.
// Depends on spd_pkg.
module spd_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [spd_pkg::SQ_W-1:0]  radicand,
    input  logic                      in_over,
    output logic                      out_valid,
    output logic [spd_pkg::OUT_W-1:0] root,
    output logic                      out_over
);
    import spd_pkg::*;

    localparam int NSTG  = OUT_W;
    localparam int REM_W = OUT_W + 4;

    logic [SQ_W-1:0]  v_reg   [NSTG-1];
    logic [REM_W-1:0] rem_reg [NSTG-1];
    logic [OUT_W-1:0] q_reg   [NSTG];
    logic             vld_reg [NSTG];
    logic             ov_reg  [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic [SQ_W-1:0]  v_in;
        logic [REM_W-1:0] rem_in;
        logic [OUT_W-1:0] q_in;
        logic             vld_in;
        logic             ov_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [OUT_W-1:0] q_next;
        logic             take;

        if (k == 0) begin : g_head
            assign v_in   = radicand;
            assign rem_in = '0;
            assign q_in   = '0;
            assign vld_in = in_valid;
            assign ov_in  = in_over;
        end else begin : g_body
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign vld_in = vld_reg[k-1];
            assign ov_in  = ov_reg[k-1];
        end

        always_comb begin
            rem_sh   = {rem_in[REM_W-3:0], v_in[SQ_W-1 -: 2]};
            trial    = {2'b00, q_in, 2'b01};
            take     = (rem_sh >= trial);
            rem_next = take ? (rem_sh - trial) : rem_sh;
            q_next   = {q_in[OUT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]  <= q_next;
                ov_reg[k] <= ov_in;
            end
        end

        if (k < NSTG - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[k]   <= v_in << 2;
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_over  = ov_reg[NSTG-1];
    assign root      = q_reg[NSTG-1] | {OUT_W{ov_reg[NSTG-1]}};

endmodule

### design/sheared_periodic_pair_distance_top.sv
`timescale 1ns / 1ps
// Sheared periodic (Lees-Edwards) minimum image pair distance, top level.
// Depends on spd_pkg, spd_cfg, spd_image, spd_resid, spd_sqrt.
//
// Takes one particle pair per beat and returns one distance beat per pair, in
// order, through 8 stages for differences, y/z image offsets and the x shear
// shift, 4 stages for wrapping, range check and the sum of squares, and 32
// stages of the bit-per-stage square root. Throughput is
// one pair per cycle. The whole pipeline advances together; it stalls only
// while an output beat is held by m_ready low, and then s_ready is low too.
// Results that do not fit are returned as all ones with m_saturated set.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata and must only be
// changed while no pair is in flight; writes to an unused index are ignored.
module sheared_periodic_pair_distance_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_first_x,
    input  logic signed [COORD_WIDTH-1:0]  s_first_y,
    input  logic signed [COORD_WIDTH-1:0]  s_first_z,
    input  logic signed [COORD_WIDTH-1:0]  s_second_x,
    input  logic signed [COORD_WIDTH-1:0]  s_second_y,
    input  logic signed [COORD_WIDTH-1:0]  s_second_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [spd_pkg::OUT_W-1:0]      m_distance,
    output logic                           m_saturated
);
    import spd_pkg::*;

    cfg_t              cfg;
    logic              en;
    logic              img_valid;
    logic [COORD_WIDTH:0] img_dx, img_dy, img_dz;
    logic [OFF_W-1:0]  img_off_y, img_off_z;
    logic [SM_W-1:0]   img_shift;
    logic              img_shift_neg;
    logic              img_over;
    logic              res_valid;
    logic [SQ_W-1:0]   res_sum;
    logic              res_over;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    spd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spd_image #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_image (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .first_x   (s_first_x),
        .first_y   (s_first_y),
        .first_z   (s_first_z),
        .second_x  (s_second_x),
        .second_y  (s_second_y),
        .second_z  (s_second_z),
        .cfg       (cfg),
        .out_valid (img_valid),
        .dx        (img_dx),
        .dy        (img_dy),
        .dz        (img_dz),
        .off_y     (img_off_y),
        .off_z     (img_off_z),
        .shift     (img_shift),
        .shift_neg (img_shift_neg),
        .over      (img_over)
    );

    spd_resid #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_resid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (img_valid),
        .dx        (img_dx),
        .dy        (img_dy),
        .dz        (img_dz),
        .off_y     (img_off_y),
        .off_z     (img_off_z),
        .shift     (img_shift),
        .shift_neg (img_shift_neg),
        .in_over   (img_over),
        .out_valid (res_valid),
        .sum_sq    (res_sum),
        .out_over  (res_over)
    );

    spd_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (res_valid),
        .radicand  (res_sum),
        .in_over   (res_over),
        .out_valid (m_valid),
        .root      (m_distance),
        .out_over  (m_saturated)
    );

endmodule
